// ===== rtl/extent_runlist_decoder_assert.svh =====
// Assertion macros shared by the assertions of the run list decoder checker.
`ifndef EXTENT_RUNLIST_DECODER_ASSERT_SVH
`define EXTENT_RUNLIST_DECODER_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define ERD_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("extent_runlist_decoder: assertion failed");

// Next-cycle implication, disabled during reset.
`define ERD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("extent_runlist_decoder: assertion failed");

`endif

// ===== rtl/erd_pkg.sv =====
// ----------------------------------------------------------------------------
// erd_pkg
// Shared constants and types for the extent run list decoder.
// ----------------------------------------------------------------------------
package erd_pkg;

    localparam int FIELD_BYTES_DEF = 8;
    localparam int NIBBLE_W        = 4;
    localparam int WORD_W          = 64;
    localparam int STATUS_W        = 2;

    localparam logic [STATUS_W-1:0] STATUS_RUN  = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_END  = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_SIZE = 2'd2;
    localparam logic [STATUS_W-1:0] STATUS_CUT  = 2'd3;

    typedef struct packed {
        logic [WORD_W-1:0]   run_start;
        logic [WORD_W-1:0]   run_length;
        logic                is_sparse;
        logic [STATUS_W-1:0] status;
    } result_t;

endpackage

// ===== rtl/erd_out_skid.sv =====
// ----------------------------------------------------------------------------
// erd_out_skid
// Result register with a skid stage, so the decoder keeps accepting bytes
// while a result waits downstream.
// ----------------------------------------------------------------------------
module erd_out_skid
    import erd_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    push,
    input  result_t push_data,
    output logic    full,
    output logic    out_valid,
    output result_t out_data,
    input  logic    out_stall
);

    logic    out_valid_reg;
    logic    skid_valid_reg;
    result_t out_data_reg;
    result_t skid_data_reg;
    logic    take;

    assign take      = out_valid_reg && !out_stall;
    assign full      = skid_valid_reg;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (skid_valid_reg)
        begin
            if (take)
            begin
                skid_valid_reg <= 1'b0;
            end
        end
        else if (push)
        begin
            if (out_valid_reg && !take)
            begin
                skid_valid_reg <= 1'b1;
            end
            else
            begin
                out_valid_reg <= 1'b1;
            end
        end
        else if (take)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (take)
            begin
                out_data_reg <= skid_data_reg;
            end
        end
        else if (push)
        begin
            if (out_valid_reg && !take)
            begin
                skid_data_reg <= push_data;
            end
            else
            begin
                out_data_reg <= push_data;
            end
        end
    end

endmodule

// ===== rtl/extent_runlist_decoder.sv =====
// ----------------------------------------------------------------------------
// extent_runlist_decoder
// Byte-serial decoder of an extent run list into absolute runs.
// ----------------------------------------------------------------------------
// Input channel: one run list byte per transaction, with first_of_list to
// open a new list and last_of_data on the final byte of the data area.
// Output channel: one transaction per finished run, end of list, oversized
// field header or list cut short, carrying run_start, run_length, is_sparse
// and status.
// Throughput: one byte per cycle while in_stall is low. Each length or
// offset byte updates the phase machine and one accumulator; the closing
// offset byte also goes through the sign extension and the 64-bit cluster
// adder in the same cycle. Each result is registered before it is presented.
// Stall: results wait in an output register backed by a one-entry skid
// stage; in_stall rises only when both are full, and drops as soon as
// the receiver takes a result.
// Reset: the decoder is stopped, the running cluster is zero and no result
// is pending; bytes are ignored until one arrives with first_of_list.
// ----------------------------------------------------------------------------
module extent_runlist_decoder
    import erd_pkg::*;
#(
    parameter int FIELD_BYTES = FIELD_BYTES_DEF
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic [7:0]          data_byte,
    input  logic                first_of_list,
    input  logic                last_of_data,
    output logic                out_valid,
    input  logic                out_stall,
    output logic [WORD_W-1:0]   run_start,
    output logic [WORD_W-1:0]   run_length,
    output logic                is_sparse,
    output logic [STATUS_W-1:0] status
);

    localparam int ACC_W = FIELD_BYTES * 8;
    localparam int POS_W = (FIELD_BYTES > 1) ? $clog2(FIELD_BYTES) : 1;
    localparam logic [NIBBLE_W-1:0] FIELD_LIMIT = NIBBLE_W'(FIELD_BYTES);

    localparam logic [1:0] PH_STOPPED = 2'd0;
    localparam logic [1:0] PH_HEADER  = 2'd1;
    localparam logic [1:0] PH_LENGTH  = 2'd2;
    localparam logic [1:0] PH_OFFSET  = 2'd3;

    logic [1:0]          phase_reg, phase_next;
    logic [NIBBLE_W-1:0] bytes_left_reg, bytes_left_next;
    logic [POS_W-1:0]    byte_pos_reg, byte_pos_next;
    logic [NIBBLE_W-1:0] offset_size_reg, offset_size_next;
    logic [ACC_W-1:0]    length_acc_reg, length_acc_next;
    logic [ACC_W-1:0]    offset_acc_reg, offset_acc_next;
    logic [WORD_W-1:0]   cluster_reg, cluster_next;

    logic                in_take;
    logic                full;
    logic [1:0]          eff_phase;
    logic [WORD_W-1:0]   cluster_eff;
    logic [NIBBLE_W-1:0] len_size;
    logic [NIBBLE_W-1:0] ofs_size;
    logic [ACC_W-1:0]    byte_ins;
    logic [ACC_W-1:0]    new_acc;
    logic [WORD_W-1:0]   ofs_zext;
    logic [WORD_W-1:0]   ofs_mask;
    logic [WORD_W-1:0]   ofs_sext;
    logic                ofs_sign;
    logic                res_valid;
    result_t             res;
    result_t             out_data;

    assign in_stall    = full;
    assign in_take     = in_valid && !full;
    assign eff_phase   = first_of_list ? PH_HEADER : phase_reg;
    assign cluster_eff = first_of_list ? '0 : cluster_reg;
    assign len_size    = data_byte[3:0];
    assign ofs_size    = data_byte[7:4];
    assign byte_ins    = ACC_W'(data_byte) << {byte_pos_reg, 3'b000};
    assign new_acc     = (phase_reg == PH_LENGTH) ? (length_acc_reg | byte_ins)
                                                  : (offset_acc_reg | byte_ins);

    // Sign-extend the completed offset from its own byte count.
    always_comb
    begin
        ofs_zext = WORD_W'(new_acc);
        ofs_sign = ofs_zext[6'({offset_size_reg, 3'b000} - 7'd1)];
        for (int i = 0; i < WORD_W / 8; i++)
        begin
            ofs_mask[i*8 +: 8] = (i < int'(offset_size_reg)) ? 8'h00 : 8'hFF;
        end
        ofs_sext = ofs_sign ? (ofs_zext | ofs_mask) : ofs_zext;
    end

    always_comb
    begin
        phase_next       = eff_phase;
        bytes_left_next  = bytes_left_reg;
        byte_pos_next    = byte_pos_reg;
        offset_size_next = offset_size_reg;
        length_acc_next  = length_acc_reg;
        offset_acc_next  = offset_acc_reg;
        cluster_next     = cluster_eff;
        res_valid        = 1'b0;
        res              = '0;

        unique case (eff_phase)
            PH_STOPPED:
            begin
            end
            PH_HEADER:
            begin
                priority if (data_byte == 8'h00)
                begin
                    res_valid  = 1'b1;
                    res.status = STATUS_END;
                    phase_next = PH_STOPPED;
                end
                else if (len_size > FIELD_LIMIT || ofs_size > FIELD_LIMIT)
                begin
                    res_valid  = 1'b1;
                    res.status = STATUS_SIZE;
                    phase_next = PH_STOPPED;
                end
                else
                begin
                    offset_size_next = ofs_size;
                    length_acc_next  = '0;
                    offset_acc_next  = '0;
                    byte_pos_next    = '0;
                    if (len_size != '0)
                    begin
                        phase_next      = PH_LENGTH;
                        bytes_left_next = len_size;
                    end
                    else
                    begin
                        phase_next      = PH_OFFSET;
                        bytes_left_next = ofs_size;
                    end
                    if (last_of_data)
                    begin
                        res_valid  = 1'b1;
                        res.status = STATUS_CUT;
                        phase_next = PH_STOPPED;
                    end
                end
            end
            PH_LENGTH:
            begin
                length_acc_next = new_acc;
                byte_pos_next   = byte_pos_reg + POS_W'(1);
                bytes_left_next = bytes_left_reg - NIBBLE_W'(1);
                if (bytes_left_reg == NIBBLE_W'(1))
                begin
                    if (offset_size_reg != '0)
                    begin
                        phase_next      = PH_OFFSET;
                        bytes_left_next = offset_size_reg;
                        byte_pos_next   = '0;
                    end
                    else
                    begin
                        res_valid      = 1'b1;
                        res.run_length = WORD_W'(new_acc);
                        res.is_sparse  = 1'b1;
                        res.status     = STATUS_RUN;
                        phase_next     = PH_HEADER;
                    end
                end
                if (last_of_data)
                begin
                    if (!res_valid)
                    begin
                        res_valid  = 1'b1;
                        res.status = STATUS_CUT;
                    end
                    phase_next = PH_STOPPED;
                end
            end
            PH_OFFSET:
            begin
                offset_acc_next = new_acc;
                byte_pos_next   = byte_pos_reg + POS_W'(1);
                bytes_left_next = bytes_left_reg - NIBBLE_W'(1);
                if (bytes_left_reg == NIBBLE_W'(1))
                begin
                    cluster_next   = cluster_eff + ofs_sext;
                    res_valid      = 1'b1;
                    res.run_start  = cluster_eff + ofs_sext;
                    res.run_length = WORD_W'(length_acc_reg);
                    res.status     = STATUS_RUN;
                    phase_next     = PH_HEADER;
                end
                if (last_of_data)
                begin
                    if (!res_valid)
                    begin
                        res_valid  = 1'b1;
                        res.status = STATUS_CUT;
                    end
                    phase_next = PH_STOPPED;
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg       <= PH_STOPPED;
            bytes_left_reg  <= '0;
            byte_pos_reg    <= '0;
            offset_size_reg <= '0;
            length_acc_reg  <= '0;
            offset_acc_reg  <= '0;
            cluster_reg     <= '0;
        end
        else if (in_take)
        begin
            phase_reg       <= phase_next;
            bytes_left_reg  <= bytes_left_next;
            byte_pos_reg    <= byte_pos_next;
            offset_size_reg <= offset_size_next;
            length_acc_reg  <= length_acc_next;
            offset_acc_reg  <= offset_acc_next;
            cluster_reg     <= cluster_next;
        end
    end

    erd_out_skid u_out_skid (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (in_take && res_valid),
        .push_data (res),
        .full      (full),
        .out_valid (out_valid),
        .out_data  (out_data),
        .out_stall (out_stall)
    );

    assign run_start  = out_data.run_start;
    assign run_length = out_data.run_length;
    assign is_sparse  = out_data.is_sparse;
    assign status     = out_data.status;

endmodule

// ===== rtl/erd_checker.sv =====
// ----------------------------------------------------------------------------
// erd_checker
// Port-level assertions for the extent run list decoder, bound to the top.
// ----------------------------------------------------------------------------
`include "extent_runlist_decoder_assert.svh"

module erd_checker
    import erd_pkg::*;
(
    input logic                clk,
    input logic                rst_n,
    input logic                in_valid,
    input logic                in_stall,
    input logic                out_valid,
    input logic                out_stall,
    input logic [WORD_W-1:0]   run_start,
    input logic [WORD_W-1:0]   run_length,
    input logic                is_sparse,
    input logic [STATUS_W-1:0] status
);

    `ERD_ASSERT_NEXT(a_in_hold, clk, rst_n, in_valid && in_stall, in_valid)
    `ERD_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid)
    `ERD_ASSERT_NOW(a_stall_only_when_backed_up, clk, rst_n, in_stall, out_valid)
    `ERD_ASSERT_NOW(a_flag_payload_zero, clk, rst_n, out_valid && status != STATUS_RUN,
                    run_start == '0 && run_length == '0 && !is_sparse)
    `ERD_ASSERT_NOW(a_sparse_start_zero, clk, rst_n, out_valid && is_sparse,
                    run_start == '0 && status == STATUS_RUN)

endmodule

bind extent_runlist_decoder erd_checker u_erd_checker (.*);

// ===== tb/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the extent run list decoder.
// ----------------------------------------------------------------------------
// Run list bytes are queued by the stimulus process and offered by a clocked
// driver. Each accepted byte goes through a local decoder model that predicts
// the result transaction, if any. A clocked monitor compares each accepted
// result with the oldest prediction. The stimulus has a directed part
// followed by random lists under four idling phases. One phase includes a
// long receiver hold-off that fills the decoder and stalls its input.
// ----------------------------------------------------------------------------
module testbench;
    import erd_pkg::*;

    localparam int LONG_HOLD  = 200;
    localparam int PHASE_ITEMS = 100;

    typedef struct packed {
        logic [7:0] data;
        logic       first;
        logic       last;
    } list_byte_t;

    typedef enum logic [1:0] {
        DEC_STOPPED,
        DEC_HEADER,
        DEC_LENGTH,
        DEC_OFFSET
    } dec_phase_e;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                in_valid = 1'b0;
    logic                in_stall;
    logic [7:0]          data_byte = 8'd0;
    logic                first_of_list = 1'b0;
    logic                last_of_data = 1'b0;
    logic                out_valid;
    logic                out_stall = 1'b0;
    logic [WORD_W-1:0]   run_start;
    logic [WORD_W-1:0]   run_length;
    logic                is_sparse;
    logic [STATUS_W-1:0] status;

    list_byte_t pending_bytes[$];
    list_byte_t list_bytes[$];
    result_t    expected_runs[$];
    result_t    predicted;
    result_t    oldest_run;

    dec_phase_e        dec_phase = DEC_STOPPED;
    logic [3:0]        bytes_due = 4'd0;
    logic [2:0]        byte_idx = 3'd0;
    logic [3:0]        ofs_size = 4'd0;
    logic [WORD_W-1:0] len_acc = '0;
    logic [WORD_W-1:0] ofs_acc = '0;
    logic [WORD_W-1:0] cur_cluster = '0;

    int send_idle = 0;
    int recv_idle = 0;
    int fail_count = 0;
    int hold_cycles = 0;
    bit hold_armed = 1'b0;

    extent_runlist_decoder dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .data_byte     (data_byte),
        .first_of_list (first_of_list),
        .last_of_data  (last_of_data),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .run_start     (run_start),
        .run_length    (run_length),
        .is_sparse     (is_sparse),
        .status        (status)
    );

    always #10 clk = ~clk;

    function automatic result_t close_run();
        result_t           r;
        logic [WORD_W-1:0] delta;
        r = '0;
        r.run_length = len_acc;
        if (ofs_size == 4'd0)
        begin
            r.is_sparse = 1'b1;
            return r;
        end
        delta = ofs_acc;
        if (ofs_size < 4'd8 && ofs_acc[ofs_size * 8 - 1])
            delta = ofs_acc | (~64'd0 << (ofs_size * 8));
        cur_cluster = cur_cluster + delta;
        r.run_start = cur_cluster;
        r.status    = STATUS_RUN;
        return r;
    endfunction

    function automatic bit decode_byte(input logic [7:0] b, input logic first,
                                       input logic last, output result_t res);
        bit got;
        got = 1'b0;
        res = '0;
        if (first)
        begin
            cur_cluster = '0;
            dec_phase   = DEC_HEADER;
        end
        case (dec_phase)
            DEC_HEADER:
            begin
                if (b == 8'd0)
                begin
                    res.status = STATUS_END;
                    dec_phase  = DEC_STOPPED;
                    return 1'b1;
                end
                if (b[3:0] > FIELD_BYTES_DEF || b[7:4] > FIELD_BYTES_DEF)
                begin
                    res.status = STATUS_SIZE;
                    dec_phase  = DEC_STOPPED;
                    return 1'b1;
                end
                ofs_size = b[7:4];
                len_acc  = '0;
                ofs_acc  = '0;
                byte_idx = 3'd0;
                if (b[3:0] != 4'd0)
                begin
                    dec_phase = DEC_LENGTH;
                    bytes_due = b[3:0];
                end
                else
                begin
                    dec_phase = DEC_OFFSET;
                    bytes_due = b[7:4];
                end
            end
            DEC_LENGTH:
            begin
                len_acc   = len_acc | ({56'd0, b} << {byte_idx, 3'b000});
                byte_idx  = byte_idx + 3'd1;
                bytes_due = bytes_due - 4'd1;
                if (bytes_due == 4'd0)
                begin
                    if (ofs_size != 4'd0)
                    begin
                        dec_phase = DEC_OFFSET;
                        bytes_due = ofs_size;
                        byte_idx  = 3'd0;
                    end
                    else
                    begin
                        res       = close_run();
                        dec_phase = DEC_HEADER;
                        got       = 1'b1;
                    end
                end
            end
            DEC_OFFSET:
            begin
                ofs_acc   = ofs_acc | ({56'd0, b} << {byte_idx, 3'b000});
                byte_idx  = byte_idx + 3'd1;
                bytes_due = bytes_due - 4'd1;
                if (bytes_due == 4'd0)
                begin
                    res       = close_run();
                    dec_phase = DEC_HEADER;
                    got       = 1'b1;
                end
            end
            default:
                return 1'b0;
        endcase
        if (last)
        begin
            if (!got)
            begin
                res.status = STATUS_CUT;
                got        = 1'b1;
            end
            dec_phase = DEC_STOPPED;
        end
        return got;
    endfunction

    always @(posedge clk)
    begin
        if (!rst_n)
            in_valid <= 1'b0;
        else
        begin
            if (in_valid && !in_stall)
            begin
                if (decode_byte(data_byte, first_of_list, last_of_data, predicted))
                    expected_runs.insert(expected_runs.size(), predicted);
                void'(pending_bytes.pop_front());
            end
            if (!(in_valid && in_stall))
            begin
                if (pending_bytes.size() != 0 && $urandom_range(99) >= send_idle)
                begin
                    in_valid      <= 1'b1;
                    data_byte     <= pending_bytes[0].data;
                    first_of_list <= pending_bytes[0].first;
                    last_of_data  <= pending_bytes[0].last;
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n)
            out_stall <= 1'b0;
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (expected_runs.size() == 0)
                begin
                    $error("result transaction with no prediction waiting");
                    fail_count++;
                end
                else
                begin
                    oldest_run = expected_runs.pop_front();
                    if (run_start !== oldest_run.run_start)
                    begin
                        $error("run_start: expected %h, actual %h",
                               oldest_run.run_start, run_start);
                        fail_count++;
                    end
                    if (run_length !== oldest_run.run_length)
                    begin
                        $error("run_length: expected %h, actual %h",
                               oldest_run.run_length, run_length);
                        fail_count++;
                    end
                    if (is_sparse !== oldest_run.is_sparse)
                    begin
                        $error("is_sparse: expected %b, actual %b",
                               oldest_run.is_sparse, is_sparse);
                        fail_count++;
                    end
                    if (status !== oldest_run.status)
                    begin
                        $error("status: expected %0d, actual %0d",
                               oldest_run.status, status);
                        fail_count++;
                    end
                end
            end
            if (hold_armed && hold_cycles < LONG_HOLD)
            begin
                out_stall   <= 1'b1;
                hold_cycles <= hold_cycles + 1;
            end
            else
                out_stall <= ($urandom_range(99) < recv_idle);
        end
    end

    task automatic push_byte(input logic [7:0] d, input logic f, input logic l);
        list_byte_t it;
        it.data  = d;
        it.first = f;
        it.last  = l;
        pending_bytes.insert(pending_bytes.size(), it);
    endtask

    task automatic stage_byte(input logic [7:0] d, input logic f, input logic l);
        list_byte_t it;
        it.data  = d;
        it.first = f;
        it.last  = l;
        list_bytes.insert(list_bytes.size(), it);
    endtask

    function automatic logic [3:0] pick_size();
        if ($urandom_range(99) < 15)
            return 4'($urandom_range(0, 8));
        return 4'($urandom_range(0, 3));
    endfunction

    task automatic stage_run(input logic first);
        logic [3:0] lsz;
        logic [3:0] osz;
        lsz = pick_size();
        osz = pick_size();
        if (lsz == 4'd0 && osz == 4'd0)
            lsz = 4'd1;
        stage_byte({osz, lsz}, first, 1'b0);
        repeat (int'(lsz) + int'(osz))
            stage_byte(8'($urandom_range(0, 255)), 1'b0, 1'b0);
    endtask

    task automatic queue_random_lists(input int item_goal);
        int         staged;
        int         runs;
        int         ending;
        int         cut;
        logic [3:0] lo;
        logic [3:0] hi;
        staged = 0;
        while (staged < item_goal)
        begin
            list_bytes.delete();
            runs = $urandom_range(1, 4);
            for (int r = 0; r < runs; r++)
                stage_run(r == 0);
            ending = $urandom_range(0, 9);
            case (ending)
                4, 5:
                    list_bytes[list_bytes.size() - 1].last = 1'b1;
                6:
                begin
                    cut = $urandom_range(0, list_bytes.size() - 1);
                    list_bytes[cut].last = 1'b1;
                    while (list_bytes.size() > cut + 1)
                        void'(list_bytes.pop_back());
                end
                7:
                begin
                    lo = 4'($urandom_range(0, 15));
                    hi = 4'($urandom_range(9, 15));
                    if ($urandom_range(1))
                        stage_byte({hi, lo}, 1'b0, 1'($urandom_range(1)));
                    else
                        stage_byte({lo, hi}, 1'b0, 1'($urandom_range(1)));
                end
                8:
                begin
                    cut = $urandom_range(1, list_bytes.size());
                    while (list_bytes.size() > cut)
                        void'(list_bytes.pop_back());
                end
                default:
                    stage_byte(8'd0, 1'b0, ($urandom_range(3) == 0));
            endcase
            staged += list_bytes.size();
            foreach (list_bytes[i])
                pending_bytes.insert(pending_bytes.size(), list_bytes[i]);
            if (ending != 8 && $urandom_range(3) == 0)
                repeat ($urandom_range(1, 2))
                    push_byte(8'($urandom_range(0, 255)), 1'b0, 1'($urandom_range(1)));
        end
    endtask

    task automatic wait_drained();
        while (pending_bytes.size() != 0 || expected_runs.size() != 0)
            @(posedge clk);
    endtask

    initial
    begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        push_byte(8'hFF, 1'b0, 1'b0);
        push_byte(8'h11, 1'b1, 1'b0);
        push_byte(8'hFF, 1'b0, 1'b0);
        push_byte(8'h80, 1'b0, 1'b0);
        push_byte(8'h01, 1'b0, 1'b0);
        push_byte(8'h00, 1'b0, 1'b0);
        push_byte(8'h10, 1'b0, 1'b0);
        push_byte(8'h7F, 1'b0, 1'b0);
        push_byte(8'h00, 1'b0, 1'b0);
        push_byte(8'h09, 1'b1, 1'b0);
        push_byte(8'h90, 1'b1, 1'b0);
        push_byte(8'h21, 1'b1, 1'b1);
        push_byte(8'h11, 1'b1, 1'b0);
        push_byte(8'h05, 1'b0, 1'b1);
        push_byte(8'h11, 1'b1, 1'b0);
        push_byte(8'h05, 1'b0, 1'b0);
        push_byte(8'h03, 1'b0, 1'b1);
        push_byte(8'h11, 1'b1, 1'b0);
        push_byte(8'h05, 1'b0, 1'b0);
        push_byte(8'h00, 1'b1, 1'b0);
        push_byte(8'h00, 1'b1, 1'b1);
        push_byte(8'hA5, 1'b0, 1'b1);
        wait_drained();

        for (int ph = 0; ph < 4; ph++)
        begin
            case (ph)
                0: begin send_idle = 0;  recv_idle = 0;  end
                1: begin send_idle = 63; recv_idle = 0;  end
                2: begin send_idle = 0;  recv_idle = 63; end
                default: begin send_idle = 28; recv_idle = 28; end
            endcase
            queue_random_lists(PHASE_ITEMS);
            if (ph == 0)
                hold_armed = 1'b1;
            wait_drained();
        end

        repeat (20) @(posedge clk);
        if (fail_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    initial
    begin
        #4_000_000;
        $display("status: fail");
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/erd_pkg.sv
rtl/erd_out_skid.sv
rtl/extent_runlist_decoder.sv
rtl/erd_checker.sv
tb/testbench.sv
